### rtl/core/lssv_pkg.sv
// Shared types, constants and kernel math for the looped sinc sample voice.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package lssv_pkg;

    localparam int SMP_W = 16;
    localparam int WT_W  = 32;
    localparam int IDX_W = 17;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] PI_Q16      = 64'd205887;

    localparam logic signed [SMP_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [SMP_W-1:0] OUT_MIN = 16'sh8000;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SAMPLE_LENGTH = 2'd0;
    localparam logic [1:0] REG_LOOP_BEGIN    = 2'd1;
    localparam logic [1:0] REG_LOOP_FINISH   = 2'd2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef struct packed {
        t_req                     kind;
        logic [15:0]              addr;
        logic signed [SMP_W-1:0]  value;
        logic [19:0]              step;
    } t_cmd;

    typedef struct packed {
        logic [16:0] sample_length;
        logic [15:0] loop_begin;
        logic [16:0] loop_finish;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SETUP,
        ST_PREP,
        ST_TAPS,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_bstate;

    // sin of u/65536 quarter turn, Q30, clamped to 1.0
    function automatic logic [63:0] f_quarter_sine(input logic [63:0] u);
        logic [63:0] th;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] r;
        th  = (u * HALF_PI_Q30) >> 16;
        t2  = (th * th) >> 30;
        acc = Q30_ONE - t2 / 64'd110;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd72;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd42;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd20;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd6;
        r   = (th * acc) >> 30;
        if (r > Q30_ONE) begin
            r = Q30_ONE;
        end
        return r;
    endfunction

    // sin of an angle in 2^-18 turn units, Q30 signed
    function automatic logic signed [63:0] f_turn_sine(input logic [63:0] a);
        logic [1:0]  q;
        logic [15:0] r;
        logic [63:0] mag;
        q   = a[17:16];
        r   = a[15:0];
        mag = q[0] ? f_quarter_sine(64'd65536 - 64'(r)) : f_quarter_sine(64'(r));
        return q[1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

### rtl/core/lssv_front.sv
// Front end: takes requests, drops no-ops and out-of-range writes, queues the rest.
// Depends on lssv_pkg.
`default_nettype none

module lssv_front import lssv_pkg::*; #(
    parameter int SAMPLE_DEPTH = 65536
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [15:0]             i_sample_addr,
    input  wire logic signed [SMP_W-1:0] i_sample_value,
    input  wire logic [19:0]             i_phase_step,
    output logic                         o_full,
    output logic                         o_cmd_valid,
    output t_cmd                         o_cmd,
    input  wire logic                    i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_req w_kind;
    logic w_keep;
    logic w_in;
    logic w_out;

    assign w_kind = t_req'(i_req_type);
    assign w_keep = (w_kind != REQ_NOP) &&
                    !((w_kind == REQ_WRITE) && ({1'b0, i_sample_addr} >= 17'(SAMPLE_DEPTH)));
    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_in        = i_push && !o_full && w_keep;
    assign w_out       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wp <= !r_wp;
            end
            if (w_out) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= '{kind: w_kind, addr: i_sample_addr,
                           value: i_sample_value, step: i_phase_step};
        end
    end

endmodule

`default_nettype wire

### rtl/core/lssv_back.sv
// Back end: sample memory, loop wrap, windowed-sinc tap loop, normalizing divide.
// Depends on lssv_pkg; fed by lssv_front, drains into lssv_outq.
`default_nettype none

module lssv_back import lssv_pkg::*; #(
    parameter int TAP_RADIUS   = 8,
    parameter int SAMPLE_DEPTH = 65536,
    parameter int PHASE_STEPS  = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd              i_cmd,
    output logic                   o_cmd_take,
    output logic                   o_res_valid,
    output logic signed [SMP_W-1:0] o_res,
    input  wire logic              i_res_full
);

    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int SPAN   = TAP_RADIUS * PHASE_STEPS;
    localparam int RIW    = $clog2(SPAN + 1);
    localparam int MW     = $clog2((TAP_RADIUS + 1) * PHASE_STEPS);
    localparam int NW     = MW + 1;
    localparam int PW     = $clog2(PHASE_STEPS);
    localparam int KW     = $clog2(TAP_RADIUS + 1) + 1;
    localparam int PROD_W = SMP_W + WT_W;
    localparam int ACC_W  = PROD_W + $clog2(2 * TAP_RADIUS) + 1;
    localparam int DEN_W  = WT_W + $clog2(2 * TAP_RADIUS) + 1;
    localparam int RW     = ACC_W + 2;

    // weight table over |offset| in 1/PHASE_STEPS sample units
    logic signed [WT_W-1:0] w_rom [SPAN+1];

    for (genvar g = 0; g <= SPAN; g++) begin : g_rom
        localparam logic [63:0] MG      = 64'(g);
        localparam logic [63:0] WIN_ARG = ((MG << 17) / SPAN) + 64'd65536;
        localparam logic signed [63:0] WSIN = f_turn_sine(WIN_ARG);
        localparam logic [63:0] WIN     = 64'(Q30_ONE + WSIN) >> 1;
        localparam logic signed [63:0] SSIN = f_turn_sine((MG << 17) / PHASE_STEPS);
        localparam logic [63:0] SMAG    = (SSIN < 0) ? 64'(-SSIN) : 64'(SSIN);
        localparam logic [63:0] SDEN    = (g == 0) ? 64'd1 : PI_Q16 * MG;
        localparam logic [63:0] SINC    = (g == 0) ? Q30_ONE :
                                          (SMAG * 64'(PHASE_STEPS) * 64'd65536) / SDEN;
        localparam bit          SNEG    = (g != 0) && (SSIN < 0);
        localparam logic [63:0] PROD    = (SINC * WIN) >> 30;
        localparam logic signed [WT_W-1:0] WV = SNEG ? -WT_W'(PROD) : WT_W'(PROD);
        assign w_rom[g] = WV;
    end

    t_bstate r_state;
    t_bstate n_state;

    logic [31:0]            r_pos;
    logic [19:0]            r_step;
    logic [3:0]             r_cnt;
    logic [15:0]            r_mrem;
    logic [31:0]            r_msh;
    logic [PW-1:0]          r_p;
    logic signed [KW-1:0]   r_k0;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_hi;
    logic signed [NW-1:0]   r_n;
    logic                   r_v1;
    logic                   r_v2;
    logic signed [SMP_W-1:0] r_smp;
    logic signed [WT_W-1:0] r_w1;
    logic signed [WT_W-1:0] r_w2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_num;
    logic signed [DEN_W-1:0] r_den;
    logic [RW-1:0]          r_rem;
    logic [RW-1:0]          r_dsh;
    logic [14:0]            r_q;
    logic                   r_neg;
    logic signed [SMP_W-1:0] r_res;
    logic signed [SMP_W-1:0] r_mem [SAMPLE_DEPTH];

    logic             w_we;
    logic             w_issue;
    logic             w_loop;
    logic             w_beyond;
    logic [16:0]      w_dl;
    logic [15:0]      w_mrem_nx;
    logic [16:0]      w_len;
    logic [IDX_W-1:0] w_ip;
    logic [IDX_W-1:0] w_lo;
    logic [IDX_W-1:0] w_top;
    logic [IDX_W-1:0] w_hi;
    logic             w_past;
    logic [MW-1:0]    w_mag;
    logic [ACC_W-1:0] w_an;
    logic [DEN_W-1:0] w_ad;
    logic [RW-1:0]    w_nn;
    logic             w_sat;
    logic             w_dbit;
    logic [14:0]      w_qn;
    logic [32:0]      w_adv;
    logic signed [NW-1:0] w_pn;

    assign o_res = r_res;

    // loop wrap: position modulo works on the integer part only
    assign w_loop    = i_cfg.loop_finish > {1'b0, i_cfg.loop_begin};
    assign w_beyond  = {1'b0, r_pos} >= {i_cfg.loop_finish, 16'b0};
    assign w_dl      = i_cfg.loop_finish - {1'b0, i_cfg.loop_begin};
    assign w_mrem_nx = ({16'b0, r_mrem} >= r_msh) ? r_mrem - r_msh[15:0] : r_mrem;

    assign w_len  = (i_cfg.sample_length > 17'(SAMPLE_DEPTH)) ? 17'(SAMPLE_DEPTH)
                                                               : i_cfg.sample_length;
    assign w_ip   = {1'b0, r_pos[31:16]};
    assign w_past = w_ip >= w_len;
    assign w_lo   = (w_ip >= IDX_W'(TAP_RADIUS)) ? w_ip - IDX_W'(TAP_RADIUS) : '0;
    assign w_top  = w_ip + IDX_W'(TAP_RADIUS);
    assign w_hi   = (w_top > w_len) ? w_len : w_top;
    assign w_pn   = $signed(NW'({1'b0, r_p}));

    assign w_issue = (r_state == ST_TAPS) && (r_idx < r_hi);
    assign w_mag   = r_n[NW-1] ? MW'(-r_n) : MW'(r_n);

    assign w_an  = r_num[ACC_W-1] ? ACC_W'(-r_num) : ACC_W'(r_num);
    assign w_ad  = r_den[DEN_W-1] ? DEN_W'(-r_den) : DEN_W'(r_den);
    assign w_nn  = (RW'(w_an) << 1) + RW'(w_ad);
    assign w_sat = w_nn >= (RW'(w_ad) << 16);

    assign w_dbit = r_rem >= r_dsh;
    assign w_qn   = {r_q[13:0], w_dbit};

    assign w_adv = {1'b0, r_pos} + 33'(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd_take  = 1'b0;
        o_res_valid = 1'b0;
        w_we        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.kind)
                        REQ_WRITE: w_we = 1'b1;
                        REQ_START: ;
                        REQ_TICK:  n_state = (w_loop && w_beyond) ? ST_WRAP : ST_SETUP;
                        REQ_NOP:   ;
                    endcase
                end
            end
            ST_WRAP:  if (r_cnt == 4'd0) n_state = ST_SETUP;
            ST_SETUP: n_state = w_past ? ST_EMIT : ST_PREP;
            ST_PREP:  n_state = ST_TAPS;
            ST_TAPS: begin
                // leave once the last tap has reached the accumulators
                if (!w_issue && !r_v1 && !r_v2) n_state = ST_CHECK;
            end
            ST_CHECK: n_state = ((r_den == '0) || w_sat) ? ST_EMIT : ST_DIV;
            ST_DIV:   if (r_cnt == 4'd0) n_state = ST_EMIT;
            ST_EMIT: begin
                o_res_valid = 1'b1;
                if (!i_res_full) n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_step <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && (i_cmd.kind == REQ_START)) begin
                        r_step <= i_cmd.step;
                        r_pos  <= '0;
                    end
                end
                ST_WRAP: begin
                    if (r_cnt == 4'd0) begin
                        r_pos <= {i_cfg.loop_begin + w_mrem_nx, r_pos[15:0]};
                    end
                end
                ST_EMIT: begin
                    if (!i_res_full) begin
                        r_pos <= w_adv[32] ? '1 : w_adv[31:0];
                    end
                end
                ST_SETUP, ST_PREP, ST_TAPS, ST_CHECK, ST_DIV: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_mrem <= r_pos[31:16] - i_cfg.loop_begin;
                r_msh  <= {15'b0, w_dl} << 15;
                r_cnt  <= 4'd15;
            end
            ST_WRAP: begin
                r_mrem <= w_mrem_nx;
                r_msh  <= r_msh >> 1;
                r_cnt  <= r_cnt - 4'd1;
            end
            ST_SETUP: begin
                r_p   <= PW'((32'(r_pos[15:0]) * 32'(PHASE_STEPS)) >> 16);
                r_idx <= w_lo;
                r_hi  <= w_hi;
                r_k0  <= KW'(w_lo - w_ip);
                r_res <= '0;
            end
            ST_PREP: begin
                r_n   <= NW'(r_k0) * NW'(PHASE_STEPS) - w_pn;
                r_num <= '0;
                r_den <= '0;
            end
            ST_TAPS: begin
                if (w_issue) begin
                    r_n   <= r_n + NW'(PHASE_STEPS);
                    r_idx <= r_idx + 1'b1;
                end
                if (r_v2) begin
                    r_num <= r_num + ACC_W'(r_prod);
                    r_den <= r_den + DEN_W'(r_w2);
                end
            end
            ST_CHECK: begin
                r_neg <= r_num[ACC_W-1] != r_den[DEN_W-1];
                r_rem <= w_nn;
                r_dsh <= RW'(w_ad) << 15;
                r_q   <= '0;
                r_cnt <= 4'd14;
                if (r_den == '0) begin
                    r_res <= '0;
                end else if (w_sat) begin
                    r_res <= (r_num[ACC_W-1] != r_den[DEN_W-1]) ? OUT_MIN : OUT_MAX;
                end
            end
            ST_DIV: begin
                if (w_dbit) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= w_qn;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_res <= r_neg ? -SMP_W'({1'b0, w_qn}) : SMP_W'({1'b0, w_qn});
                end
            end
            ST_EMIT: ;
        endcase
    end

    // tap pipeline: memory and weight read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_w1   <= (w_mag > MW'(SPAN)) ? '0 : w_rom[w_mag[RIW-1:0]];
        r_prod <= PROD_W'(r_smp) * PROD_W'(r_w1);
        r_w2   <= r_w1;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_cmd.addr[AW-1:0]] <= i_cmd.value;
        end
        r_smp <= r_mem[r_idx[AW-1:0]];
    end

endmodule

`default_nettype wire

### rtl/core/lssv_outq.sv
// Two-entry result queue between the back end and the output ports.
// Depends on lssv_pkg.
`default_nettype none

module lssv_outq import lssv_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire logic signed [SMP_W-1:0] i_data,
    output logic                         o_full,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output logic signed [SMP_W-1:0]      o_data
);

    logic signed [SMP_W-1:0] r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_in;
    logic       w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_q[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wp <= !r_wp;
            end
            if (w_out) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/looped_sinc_sample_voice.sv
// Top level of the looped sinc sample voice: config registers and the three parts.
// Depends on lssv_pkg, lssv_front, lssv_back, lssv_outq.
//
//   channel   direction  handshake                   payload
//   request   in         push / full                 i_req_type, i_sample_addr,
//                                                    i_sample_value, i_phase_step
//   result    out        empty / pop                 o_sample_out
//   config    in         psel penable pwrite pready  paddr, pwdata, prdata
//
// Write and start requests are handled in the back-end idle state. A tick is paced by the
// tap loop through the single sample memory port and the one-bit-per-cycle normalizing
// divide; a tick that wraps the loop first steps through the serial modulo of the wrap state.
// Reset is synchronous and clears position, step and all queues; memory is not cleared.
// A two-deep request queue and a two-deep result queue let either side stall alone.
`default_nettype none

module looped_sinc_sample_voice import lssv_pkg::*; #(
    parameter int TAP_RADIUS   = 8,
    parameter int SAMPLE_DEPTH = 65536,
    parameter int PHASE_STEPS  = 256
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [15:0]             i_sample_addr,
    input  wire logic signed [SMP_W-1:0] i_sample_value,
    input  wire logic [19:0]             i_phase_step,
    output logic                         empty,
    input  wire logic                    pop,
    output logic signed [SMP_W-1:0]      o_sample_out,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    t_cfg r_cfg;

    logic                    w_cfg_we;
    logic                    w_cmd_valid;
    t_cmd                    w_cmd;
    logic                    w_cmd_take;
    logic                    w_res_valid;
    logic signed [SMP_W-1:0] w_res;
    logic                    w_res_full;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_we) begin
            unique case (paddr[3:2])
                REG_SAMPLE_LENGTH: r_cfg.sample_length <= pwdata[16:0];
                REG_LOOP_BEGIN:    r_cfg.loop_begin    <= pwdata[15:0];
                REG_LOOP_FINISH:   r_cfg.loop_finish   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SAMPLE_LENGTH: prdata = 32'(r_cfg.sample_length);
            REG_LOOP_BEGIN:    prdata = 32'(r_cfg.loop_begin);
            REG_LOOP_FINISH:   prdata = 32'(r_cfg.loop_finish);
            default:           prdata = '0;
        endcase
    end

    lssv_front #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_req_type     (i_req_type),
        .i_sample_addr  (i_sample_addr),
        .i_sample_value (i_sample_value),
        .i_phase_step   (i_phase_step),
        .o_full         (full),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_take     (w_cmd_take)
    );

    lssv_back #(
        .TAP_RADIUS   (TAP_RADIUS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .PHASE_STEPS  (PHASE_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    lssv_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_sample_out)
    );

endmodule

`default_nettype wire

### tb/sv/looped_sinc_sample_voice_tb.sv
// Self-checking testbench for looped_sinc_sample_voice: random and directed requests,
// a fixed-point voice predictor in a scoreboard class, APB register writes between phases.
// Depends on lssv_pkg and the looped_sinc_sample_voice RTL.
`default_nettype none

module looped_sinc_sample_voice_tb;
    import lssv_pkg::*;

    localparam int RADIUS = 8;
    localparam int DEPTH  = 65536;
    localparam int PSTEPS = 256;
    localparam int SETTLE = 80;

    class voice_scoreboard;
        logic [15:0] mem [DEPTH];
        bit          written [DEPTH];
        logic [31:0] position;
        logic [19:0] step;
        logic [16:0] length;
        logic [15:0] loop_lo;
        logic [16:0] loop_hi;
        logic signed [15:0] expected_samples [$];
        int errors;

        function new();
            position = 0;
            step     = 0;
            length   = 0;
            loop_lo  = 0;
            loop_hi  = 0;
            errors   = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function longint unsigned quarter_sin(longint unsigned u);
            longint unsigned th, t2, acc, r;
            th  = (u * 64'd1686629713) >> 16;
            t2  = (th * th) >> 30;
            acc = 64'd1073741824 - t2 / 110;
            acc = 64'd1073741824 - ((t2 * acc) >> 30) / 72;
            acc = 64'd1073741824 - ((t2 * acc) >> 30) / 42;
            acc = 64'd1073741824 - ((t2 * acc) >> 30) / 20;
            acc = 64'd1073741824 - ((t2 * acc) >> 30) / 6;
            r   = (th * acc) >> 30;
            if (r > 64'd1073741824) r = 64'd1073741824;
            return r;
        endfunction

        function longint angle_sin(longint unsigned a);
            longint unsigned q, r;
            longint mag;
            a   = a & 64'h3FFFF;
            q   = a >> 16;
            r   = a & 64'hFFFF;
            mag = q[0] ? longint'(quarter_sin(65536 - r)) : longint'(quarter_sin(r));
            return q[1] ? -mag : mag;
        endfunction

        // Q30 sinc times Hann weight at offset n (1/PSTEPS sample units)
        function longint tap_weight(longint n);
            longint unsigned m, span, smag, prod, win;
            longint s, sinc, mag;
            m    = (n < 0) ? -n : n;
            span = RADIUS * PSTEPS;
            if (m > span) return 0;
            win = longint'(64'd1073741824 + angle_sin(((m << 17) / span) + 65536)) / 2;
            if (m == 0) begin
                sinc = 64'd1073741824;
            end else begin
                s    = angle_sin((m << 17) / PSTEPS);
                smag = (s < 0) ? -s : s;
                mag  = (smag * PSTEPS * 65536) / (64'd205887 * m);
                sinc = (s < 0) ? -mag : mag;
            end
            smag = (sinc < 0) ? -sinc : sinc;
            prod = (smag * win) >> 30;
            return (sinc < 0) ? -longint'(prod) : longint'(prod);
        endfunction

        function longint unsigned eff_len();
            return (length > DEPTH) ? DEPTH : length;
        endfunction

        function logic [31:0] wrapped_pos();
            longint unsigned pos, b, e;
            pos = position;
            if (loop_hi > loop_lo) begin
                b = longint'(loop_lo) << 16;
                e = longint'(loop_hi) << 16;
                if (pos >= e) pos = b + (pos - b) % (e - b);
            end
            return pos[31:0];
        endfunction

        // first tap the next tick would read that was never written, or -1
        function int missing_tap();
            longint unsigned len, ip, lo, hi;
            len = eff_len();
            ip  = wrapped_pos() >> 16;
            if (ip >= len) return -1;
            lo = (ip >= RADIUS) ? ip - RADIUS : 0;
            hi = (ip + RADIUS > len) ? len : ip + RADIUS;
            for (longint unsigned i = lo; i < hi; i++) begin
                if (!written[i]) return int'(i);
            end
            return -1;
        endfunction

        function logic signed [15:0] interpolate();
            longint unsigned len, ip, lo, hi, an, ad, q;
            longint p, num, den, w, sv;
            len = eff_len();
            ip  = position >> 16;
            p   = (longint'(position[15:0]) * PSTEPS) >> 16;
            if (ip >= len) return 0;
            lo  = (ip >= RADIUS) ? ip - RADIUS : 0;
            hi  = (ip + RADIUS > len) ? len : ip + RADIUS;
            num = 0;
            den = 0;
            for (longint unsigned i = lo; i < hi; i++) begin
                w   = tap_weight((longint'(i) - longint'(ip)) * PSTEPS - p);
                sv  = longint'($signed(mem[i]));
                num += sv * w;
                den += w;
            end
            if (den == 0) return 0;
            an = (num < 0) ? -num : num;
            ad = (den < 0) ? -den : den;
            q  = (an * 2 + ad) / (ad * 2);
            if ((num < 0) != (den < 0)) begin
                if (q > 32768) q = 32768;
                return -$signed(17'(q));
            end
            if (q > 32767) q = 32767;
            return q[15:0];
        endfunction

        function void note_request(t_req kind, logic [15:0] addr, logic [15:0] value,
                                   logic [19:0] stp);
            longint unsigned pos;
            logic signed [15:0] y;
            case (kind)
                REQ_WRITE: begin
                    mem[addr]     = value;
                    written[addr] = 1;
                end
                REQ_START: begin
                    step     = stp;
                    position = 0;
                end
                REQ_TICK: begin
                    position = wrapped_pos();
                    y        = interpolate();
                    expected_samples = {expected_samples, y};
                    pos      = longint'(position) + step;
                    position = (pos > 64'hFFFFFFFF) ? 32'hFFFFFFFF : pos[31:0];
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %0d", got);
                return;
            end
            want = expected_samples.pop_front();
            if (want !== got) begin
                errors++;
                if (errors <= 10) $display("sample_out mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_req_type;
    logic [15:0]        i_sample_addr;
    logic signed [15:0] i_sample_value;
    logic [19:0]        i_phase_step;
    logic               empty;
    logic               pop;
    logic signed [15:0] o_sample_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    voice_scoreboard sb;
    bit hold_req;

    looped_sinc_sample_voice dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_req_type(i_req_type), .i_sample_addr(i_sample_addr),
        .i_sample_value(i_sample_value), .i_phase_step(i_phase_step),
        .empty(empty), .pop(pop), .o_sample_out(o_sample_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("looped_sinc_sample_voice_tb: errors");
        $finish;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one request, hold it until accepted, then maybe idle
    task automatic send(t_req kind, logic [15:0] addr, logic [15:0] value, logic [19:0] stp,
                        bit allow_gap = 1);
        int g;
        push           <= 1;
        i_req_type     <= kind;
        i_sample_addr  <= addr;
        i_sample_value <= value;
        i_phase_step   <= stp;
        do @(posedge i_clk); while (full);
        sb.note_request(kind, addr, value, stp);
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            push <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic tick(bit allow_gap = 1);
        int a;
        a = sb.missing_tap();
        while (a >= 0) begin
            send(REQ_WRITE, a[15:0], 16'($urandom), 20'($urandom), allow_gap);
            a = sb.missing_tap();
        end
        send(REQ_TICK, 16'($urandom), 16'($urandom), 20'($urandom), allow_gap);
    endtask

    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (sb.expected_samples.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        case (idx)
            REG_SAMPLE_LENGTH: sb.length  = value[16:0];
            REG_LOOP_BEGIN:    sb.loop_lo = value[15:0];
            REG_LOOP_FINISH:   sb.loop_hi = value[16:0];
            default: ;
        endcase
    endtask

    task automatic set_voice(logic [31:0] len, logic [31:0] lb, logic [31:0] lf);
        drain();
        reg_write(REG_SAMPLE_LENGTH, len);
        reg_write(REG_LOOP_BEGIN, lb);
        reg_write(REG_LOOP_FINISH, lf);
    endtask

    task automatic random_request();
        int r;
        logic [19:0] stp;
        logic [15:0] addr;
        r = $urandom_range(0, 99);
        if (r < 55 || r >= 93) begin
            tick();
        end else if (r < 80) begin
            if ($urandom_range(0, 9) == 0) addr = 16'($urandom);
            else addr = 16'($urandom_range(0, (sb.length > 300) ? 300 : sb.length + 8));
            send(REQ_WRITE, addr, 16'($urandom), 20'($urandom));
        end else if (r < 88) begin
            stp = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 'h28000));
            send(REQ_START, 16'($urandom), 16'($urandom), stp);
        end else begin
            send(REQ_NOP, 16'($urandom), 16'($urandom), 20'($urandom));
        end
    endtask

    // result side: random pops, a long hold-off on request
    initial begin
        int stall;
        stall = 0;
        pop <= 0;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                stall = 400;
            end
            if (stall > 0) begin
                stall--;
                pop <= 0;
            end else if ($urandom_range(0, 99) < 12) begin
                stall = gap_len();
                pop <= 0;
            end else begin
                pop <= 1;
            end
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(o_sample_out);
        end
    end

    initial begin
        int lens [7] = '{64, 200, 20, 131071, 0, 40, 65536};
        int lbs  [7] = '{8, 0, 30, 100, 0, 39, 65535};
        int lfs  [7] = '{40, 200, 10, 160, 0, 40, 65536};
        sb = new();
        hold_req = 0;
        i_rst_n = 0;
        push = 0;
        i_req_type = REQ_NOP;
        i_sample_addr = 0;
        i_sample_value = 0;
        i_phase_step = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes of samples and steps, no-op, far address
        set_voice(32, 0, 0);
        for (int i = 0; i < 32; i++) begin
            send(REQ_WRITE, 16'(i), (i % 2) ? 16'sh7fff : 16'sh8000, 0, 0);
        end
        send(REQ_WRITE, 16'hFFFF, 16'h5A5A, 20'hFFFFF);
        send(REQ_NOP, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        send(REQ_START, 0, 0, 20'h00000);
        tick();
        tick();
        send(REQ_START, 0, 0, 20'h10000);
        tick();
        tick();
        send(REQ_START, 0, 0, 20'h08000);
        tick();
        tick();
        send(REQ_START, 0, 0, 20'hFFFFF);
        repeat (4) tick();
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            set_voice(lens[ph], lbs[ph], lfs[ph]);
            send(REQ_START, 0, 0, 20'($urandom_range(0, 'h20000)));
            if (ph == 1) hold_req = 1;
            repeat (150) random_request();
            if (ph == 3) begin
                // pause until every result is back
                drain();
                repeat (20) tick();
            end
        end

        // run the position far past the sample end, then wrap it back into a loop
        set_voice(0, 0, 0);
        send(REQ_START, 0, 0, 20'hFFFFF);
        repeat (100) tick(0);
        set_voice(16, 0, 16);
        repeat (20) tick();

        drain();
        if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
            $display("looped_sinc_sample_voice_tb: clean");
        end else begin
            $display("looped_sinc_sample_voice_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
